>>> rtl/i2cws_pkg.sv
// Shared types, constants and helpers for the I2C write frame serializer.
`timescale 1ns / 1ps
`default_nettype none

package i2cws_pkg;

  // Frame geometry.
  localparam int BYTES_PER_FRAME = 3;
  localparam int FRAME_W         = BYTES_PER_FRAME * 8;
  localparam int LATCH_W         = 24;
  localparam int PAD_W           = FRAME_W + LATCH_W;
  localparam int BYTE_IDX_W      = (BYTES_PER_FRAME > 1) ? $clog2(BYTES_PER_FRAME) : 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] ADDR_RESET     = 8'h78;
  localparam logic [7:0] CMD_CTL_RESET  = 8'h00;
  localparam logic [7:0] DATA_CTL_RESET = 8'h40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDRESS  = 2'd0,
    CFG_COMMAND  = 2'd1,
    CFG_DATA_CTL = 2'd2
  } cfg_idx_t;

  // Item kinds.
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  // Segments of a frame; idle means no frame in flight.
  typedef enum logic [1:0] {
    SEG_IDLE  = 2'd0,
    SEG_START = 2'd1,
    SEG_BYTE  = 2'd2,
    SEG_STOP  = 2'd3
  } seg_t;

  // Write counter within a segment.
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] START_LAST = 5'd3;
  localparam logic [CNT_W-1:0] BIT_WRITES = 5'd24;
  localparam logic [CNT_W-1:0] ACK_HIGH   = 5'd24;
  localparam logic [CNT_W-1:0] ACK_LOW    = 5'd25;
  localparam logic [CNT_W-1:0] STOP_LAST  = 5'd2;

  // Phase of one data bit: drive SDA, raise SCL, drop SCL.
  localparam int PH_W = 2;
  localparam logic [PH_W-1:0] PH_DATA = 2'd0;
  localparam logic [PH_W-1:0] PH_HIGH = 2'd1;
  localparam logic [PH_W-1:0] PH_LOW  = 2'd2;

  // One queue entry: the classified item.
  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Frame bytes: address, control, payload, then zeros for any later byte.
  function automatic logic [FRAME_W-1:0] build_frame(input logic [7:0] addr,
                                                     input logic [7:0] ctl,
                                                     input logic [7:0] payload);
    logic [PAD_W-1:0] wide;
    wide = {addr, ctl, payload, {FRAME_W{1'b0}}};
    return wide[PAD_W-1 -: FRAME_W];
  endfunction

endpackage

`default_nettype wire

>>> rtl/i2cws_front.sv
// Front part: configuration registers and classification of incoming items.
`timescale 1ns / 1ps
`default_nettype none

module i2cws_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2cws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic                          in_is_data,
  input  logic [7:0]                    in_payload,
  input  i2cws_pkg::q_status_t          q_status,
  output logic                          push,
  output i2cws_pkg::entry_t             push_entry
);
  import i2cws_pkg::*;

  logic [7:0] addr_r;
  logic [7:0] cmd_ctl_r;
  logic [7:0] data_ctl_r;
  logic [7:0] ctl_sel;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= ADDR_RESET;
      cmd_ctl_r  <= CMD_CTL_RESET;
      data_ctl_r <= DATA_CTL_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ADDRESS:  addr_r     <= cfg_wdata;
        CFG_COMMAND:  cmd_ctl_r  <= cfg_wdata;
        CFG_DATA_CTL: data_ctl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Classify the item and assemble the frame a request would start.
  assign ctl_sel          = in_is_data ? data_ctl_r : cmd_ctl_r;
  assign push_entry.op    = op_t'(in_operation);
  assign push_entry.frame = build_frame(addr_r, ctl_sel, in_payload);

endmodule

`default_nettype wire

>>> rtl/i2cws_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module i2cws_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  i2cws_pkg::entry_t    push_entry,
  input  logic                 pop,
  output i2cws_pkg::entry_t    pop_entry,
  output i2cws_pkg::q_status_t q_status
);
  import i2cws_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  assign pop_entry      = mem_r[rd_ptr_r];
  assign q_status.full  = (count_r == 2'd2);
  assign q_status.empty = (count_r == 2'd0);

endmodule

`default_nettype wire

>>> rtl/i2cws_back.sv
// Back part: frame sequencer, pin levels and the registered result.
`timescale 1ns / 1ps
`default_nettype none

module i2cws_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cws_pkg::q_status_t q_status,
  input  i2cws_pkg::entry_t    pop_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_scl,
  output logic                 out_sda,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic                 out_rejected
);
  import i2cws_pkg::*;

  seg_t                  seg_r, seg_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PH_W-1:0]       ph_r, ph_nxt;
  logic [BYTE_IDX_W-1:0] byte_r, byte_nxt;
  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  busy_out_r, done_out_r, rej_out_r;
  logic                  done_nxt, rej_nxt;
  logic                  is_req, is_tick, last_byte;

  // Take the next item when the result register is free or being drained.
  assign pop           = !q_status.empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  assign is_req    = (pop_entry.op == OP_REQUEST);
  assign is_tick   = (pop_entry.op == OP_TICK);
  assign last_byte = (byte_r == BYTE_IDX_W'(BYTES_PER_FRAME - 1));

  // Next segment.
  always_comb begin
    seg_nxt = seg_r;
    if (is_req) begin
      if (seg_r == SEG_IDLE) begin
        seg_nxt = SEG_START;
      end
    end else begin
      case (seg_r)
        SEG_START: if (cnt_r == START_LAST) seg_nxt = SEG_BYTE;
        SEG_BYTE:  if (cnt_r == ACK_LOW && last_byte) seg_nxt = SEG_STOP;
        SEG_STOP:  if (cnt_r == STOP_LAST) seg_nxt = SEG_IDLE;
        default:   seg_nxt = seg_r;
      endcase
    end
  end

  // Pin writes, counters and flags for the item being executed.
  always_comb begin
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    byte_nxt  = byte_r;
    frame_nxt = frame_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done_nxt  = 1'b0;
    rej_nxt   = 1'b0;
    if (is_req) begin
      if (seg_r == SEG_IDLE) begin
        frame_nxt = pop_entry.frame;
        cnt_nxt   = '0;
        ph_nxt    = PH_DATA;
        byte_nxt  = '0;
      end else begin
        rej_nxt = 1'b1;
      end
    end else if (is_tick) begin
      case (seg_r)
        SEG_START: begin
          case (cnt_r)
            5'd0:    sda_nxt = 1'b1;
            5'd1:    scl_nxt = 1'b1;
            5'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
          cnt_nxt = (cnt_r == START_LAST) ? '0 : cnt_r + CNT_W'(1);
        end
        SEG_BYTE: begin
          if (cnt_r >= BIT_WRITES) begin
            // Acknowledge clock; the acknowledge is not sampled.
            if (cnt_r == ACK_HIGH) begin
              scl_nxt = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              scl_nxt = 1'b0;
              cnt_nxt = '0;
              ph_nxt  = PH_DATA;
              if (!last_byte) begin
                byte_nxt = byte_r + BYTE_IDX_W'(1);
              end
            end
          end else begin
            case (ph_r)
              PH_DATA: sda_nxt = frame_r[FRAME_W-1];
              PH_HIGH: scl_nxt = 1'b1;
              default: begin
                scl_nxt   = 1'b0;
                frame_nxt = {frame_r[FRAME_W-2:0], 1'b0};
              end
            endcase
            ph_nxt  = (ph_r == PH_LOW) ? PH_DATA : ph_r + PH_W'(1);
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        SEG_STOP: begin
          case (cnt_r)
            5'd0:    sda_nxt = 1'b0;
            5'd1:    scl_nxt = 1'b1;
            default: begin
              sda_nxt  = 1'b1;
              done_nxt = 1'b1;
            end
          endcase
          cnt_nxt = (cnt_r == STOP_LAST) ? '0 : cnt_r + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Sequencer state and pins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_IDLE;
      cnt_r       <= '0;
      ph_r        <= PH_DATA;
      byte_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        seg_r  <= seg_nxt;
        cnt_r  <= cnt_nxt;
        ph_r   <= ph_nxt;
        byte_r <= byte_nxt;
        scl_r  <= scl_nxt;
        sda_r  <= sda_nxt;
      end
    end
  end

  // Frame shifter and result flags carry no reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r    <= frame_nxt;
      busy_out_r <= (seg_nxt != SEG_IDLE);
      done_out_r <= done_nxt;
      rej_out_r  <= rej_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl        = scl_r;
  assign out_sda        = sda_r;
  assign out_busy_res   = busy_out_r;
  assign out_frame_done = done_out_r;
  assign out_rejected   = rej_out_r;

endmodule

`default_nettype wire

>>> rtl/i2c_write_frame_serializer.sv
// Top level of the write-only I2C frame serializer.
//
//   Port group   Direction   Handshake        Carries
//   in_*         input       valid / stall    operation, is_data, payload
//   out_*        output      valid / stall    scl, sda, busy_res, frame_done, rejected
//   cfg_*        input       write enable     register index and 8-bit data
//
// The sequencer executes one item per cycle unless a stall on the result side holds it.
// An item's result passes through the queue and then the result register before it is taken.
// Reset is synchronous and active low; it leaves both pins high and the block idle.
// A stall on the result side fills the two-entry queue before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module i2c_write_frame_serializer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [i2cws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic                             in_is_data,
  input  logic [7:0]                       in_payload,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_scl,
  output logic                             out_sda,
  output logic                             out_busy_res,
  output logic                             out_frame_done,
  output logic                             out_rejected
);
  import i2cws_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    pop_entry;
  logic      push;
  logic      pop;

  // Accept and classify.
  i2cws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_operation (in_operation),
    .in_is_data (in_is_data),
    .in_payload (in_payload),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple the two sides.
  i2cws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  // Execute and report.
  i2cws_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl        (out_scl),
    .out_sda        (out_sda),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done),
    .out_rejected   (out_rejected)
  );

endmodule

`default_nettype wire

>>> rtl/i2cws_checker.sv
// Port-level checks for the serializer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cws_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_scl,
  input logic out_sda,
  input logic out_busy_res,
  input logic out_frame_done,
  input logic out_rejected
);

  // The final stop write ends the frame.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res && !out_rejected)
    else $error("frame_done reported while still busy");

  // A request is only dropped while a frame is in flight.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("request rejected while idle");

  // With no frame in flight the bus rests with both lines high.
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl && out_sda)
    else $error("bus lines not released while idle");

  // A stalled result holds its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scl) && $stable(out_sda)
      && $stable(out_busy_res) && $stable(out_frame_done) && $stable(out_rejected))
    else $error("stalled result changed");

endmodule

bind i2c_write_frame_serializer i2cws_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_scl        (out_scl),
  .out_sda        (out_sda),
  .out_busy_res   (out_busy_res),
  .out_frame_done (out_frame_done),
  .out_rejected   (out_rejected)
);

`default_nettype wire
